// ===== rtl/core/tln_pkg.sv =====
package tln_pkg;

    localparam int unsigned IDX_W     = 14;
    localparam int unsigned MEM_DEPTH = 1 << IDX_W;
    localparam int unsigned SUM_W     = 32;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned SF_W      = 24;
    localparam int unsigned NC_W      = 15;
    localparam int unsigned CFG_W     = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned NORM_W    = 41;
    localparam int unsigned FRAC_W    = 30;
    localparam int unsigned LOG_W     = 36;
    localparam int unsigned TERM_W    = 30;

    localparam logic [31:0]      LN2_Q32        = 32'hB172_17F8;
    localparam logic [SF_W-1:0]  SF_RESET       = 24'd100000;
    localparam logic [NC_W-1:0]  NC_RESET       = 15'd16384;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd2;

    typedef enum logic [1:0] {
        OP_ACC    = 2'd0,
        OP_XFORM  = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_IGNORE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_OK  = 2'd0,
        ERR_COL = 2'd1,
        ERR_ROW = 2'd2
    } t_err;

endpackage

// ===== rtl/core/tln_ram.sv =====
// single write port, single registered read port
module tln_ram (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tln_pkg::IDX_W-1:0]  i_waddr,
    input  logic [tln_pkg::SUM_W-1:0]  i_wdata,
    input  logic [tln_pkg::IDX_W-1:0]  i_raddr,
    output logic [tln_pkg::SUM_W-1:0]  o_rdata
);

    logic [tln_pkg::SUM_W-1:0] r_mem [tln_pkg::MEM_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/tln_mul.sv =====
// shared 32x32 multiplier, product registered
module tln_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    always_ff @(posedge i_clk) begin
        o_prod <= 64'(i_a) * 64'(i_b);
    end

endmodule

// ===== rtl/core/tfidf_log_normalizer_top.sv =====
// TF-IDF log normaliser over sparse count words. An accumulate word adds its value to a
// row sum and a column sum (saturating at 32 bits); a transform word returns, in mode 1,
// ln(1 + value*scale/colsum) * ln(1 + num_cols/rowsum) as unsigned Q16.16, or in
// mode 0 the value shifted to Q16.16; a clear word zeroes both sum stores. One word is
// handled at a time and the input is not ready meanwhile. After reset and after every
// clear word a clearing pass writes zero to all 16384 entries of both sum memories. A
// mode-1 transform on a zero column sum, else a zero row sum, returns zero and an error
// code. A full transform is built on the four base-2 logarithms, each a normalising
// shift of up to 11 steps and 30 squarings through the one shared 32x32 multiplier,
// followed by the product and two multiplies by ln2 on that same unit.
// A finished result sits in an output register while the next word is accepted.
module tfidf_log_normalizer_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [tln_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tln_pkg::CFG_W-1:0]       i_cfg_data,
    // input words
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_opcode,
    input  logic [tln_pkg::IDX_W-1:0]       i_row_index,
    input  logic [tln_pkg::IDX_W-1:0]       i_col_index,
    input  logic [tln_pkg::VAL_W-1:0]       i_entry_value,
    // result words
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tln_pkg::IDX_W-1:0]       o_row_out,
    output logic [tln_pkg::IDX_W-1:0]       o_col_out,
    output logic [31:0]                     o_norm_value,
    output logic [1:0]                      o_error_code
);

    typedef enum logic [18:0] {
        S_CLR  = 19'h00001,
        S_IDLE = 19'h00002,
        S_RD   = 19'h00004,
        S_ACC  = 19'h00008,
        S_CHK  = 19'h00010,
        S_MA   = 19'h00020,
        S_MAW  = 19'h00040,
        S_LOAD = 19'h00080,
        S_NORM = 19'h00100,
        S_SQ0  = 19'h00200,
        S_SQ   = 19'h00400,
        S_LEND = 19'h00800,
        S_MT   = 19'h01000,
        S_MTW  = 19'h02000,
        S_Q1   = 19'h04000,
        S_Q2   = 19'h08000,
        S_Q3   = 19'h10000,
        S_RND  = 19'h20000,
        S_OUT  = 19'h40000
    } t_state;

    t_state r_state;

    // configuration registers
    logic                          r_mode;
    logic [tln_pkg::SF_W-1:0]      r_sf;
    logic [tln_pkg::NC_W-1:0]      r_nc;

    // captured word
    logic [1:0]                    r_op;
    logic [tln_pkg::IDX_W-1:0]     r_row;
    logic [tln_pkg::IDX_W-1:0]     r_col;
    logic [tln_pkg::VAL_W-1:0]     r_val;

    logic [tln_pkg::IDX_W-1:0]     r_clr_addr;

    // log datapath
    logic [39:0]                   r_a;        // value * scale
    logic [tln_pkg::NORM_W-1:0]    r_n;        // operand being normalised
    logic [5:0]                    r_sh;
    logic [31:0]                   r_m;        // Q1.31 mantissa
    logic [tln_pkg::FRAC_W-1:0]    r_frac;
    logic [4:0]                    r_cnt;
    logic [1:0]                    r_lsel;     // which of the four logs
    logic [tln_pkg::LOG_W-1:0]     r_hi;
    logic [tln_pkg::TERM_W-1:0]    r_t1;
    logic [tln_pkg::TERM_W-1:0]    r_t2;
    logic [63:0]                   r_x;
    logic [63:0]                   r_acc;
    logic                          r_pass;
    logic [31:0]                   r_res;
    logic [1:0]                    r_err;

    logic [tln_pkg::SUM_W-1:0]     w_rs;
    logic [tln_pkg::SUM_W-1:0]     w_cs;
    logic [tln_pkg::SUM_W-1:0]     w_rs_sat;
    logic [tln_pkg::SUM_W-1:0]     w_cs_sat;
    logic [tln_pkg::SUM_W:0]       w_rs_sum;
    logic [tln_pkg::SUM_W:0]       w_cs_sum;
    logic                          w_we;
    logic [tln_pkg::IDX_W-1:0]     w_row_waddr;
    logic [tln_pkg::IDX_W-1:0]     w_col_waddr;
    logic [tln_pkg::SUM_W-1:0]     w_row_wdata;
    logic [tln_pkg::SUM_W-1:0]     w_col_wdata;

    logic [31:0]                   w_mul_a;
    logic [31:0]                   w_mul_b;
    logic [63:0]                   w_prod;
    logic [31:0]                   w_mnext;
    logic [5:0]                    w_p;
    logic [tln_pkg::LOG_W-1:0]     w_log;
    logic [tln_pkg::LOG_W-1:0]     w_diff;
    logic [tln_pkg::NORM_W-1:0]    w_load;
    logic [63:0]                   w_rnd;

    logic                          w_in_acc;
    logic                          w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    // sum stores: clearing pass or saturating read-modify-write
    assign w_rs_sum = {1'b0, w_rs} + {{(tln_pkg::SUM_W + 1 - tln_pkg::VAL_W){1'b0}}, r_val};
    assign w_cs_sum = {1'b0, w_cs} + {{(tln_pkg::SUM_W + 1 - tln_pkg::VAL_W){1'b0}}, r_val};
    assign w_rs_sat = w_rs_sum[tln_pkg::SUM_W] ? '1 : w_rs_sum[tln_pkg::SUM_W-1:0];
    assign w_cs_sat = w_cs_sum[tln_pkg::SUM_W] ? '1 : w_cs_sum[tln_pkg::SUM_W-1:0];

    assign w_we        = (r_state == S_CLR) || (r_state == S_ACC);
    assign w_row_waddr = (r_state == S_CLR) ? r_clr_addr : r_row;
    assign w_col_waddr = (r_state == S_CLR) ? r_clr_addr : r_col;
    assign w_row_wdata = (r_state == S_CLR) ? '0 : w_rs_sat;
    assign w_col_wdata = (r_state == S_CLR) ? '0 : w_cs_sat;

    tln_ram u_row_sums (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_row_waddr),
        .i_wdata (w_row_wdata),
        .i_raddr (r_row),
        .o_rdata (w_rs)
    );

    tln_ram u_col_sums (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_col_waddr),
        .i_wdata (w_col_wdata),
        .i_raddr (r_col),
        .o_rdata (w_cs)
    );

    // next mantissa from the last square
    assign w_mnext = w_prod[63] ? w_prod[63:32] : w_prod[62:31];

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MA: begin
                w_mul_a = {16'b0, r_val};
                w_mul_b = {8'b0, r_sf};
            end
            S_SQ0: begin
                w_mul_a = r_m;
                w_mul_b = r_m;
            end
            S_SQ: begin
                w_mul_a = w_mnext;
                w_mul_b = w_mnext;
            end
            S_MT: begin
                w_mul_a = {2'b0, r_t1};
                w_mul_b = {2'b0, r_t2};
            end
            S_Q1: begin
                w_mul_a = r_x[63:32];
                w_mul_b = tln_pkg::LN2_Q32;
            end
            S_Q2: begin
                w_mul_a = r_x[31:0];
                w_mul_b = tln_pkg::LN2_Q32;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    tln_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // log2 in Q.30 and the clamped difference
    assign w_p    = 6'd40 - r_sh;
    assign w_log  = {w_p, r_frac};
    assign w_diff = (r_hi > w_log) ? (r_hi - w_log) : '0;
    assign w_rnd  = r_x + 64'h0000_0000_8000_0000;

    always_comb begin
        case (r_lsel)
            2'd0:    w_load = {1'b0, r_a} + {9'b0, w_cs};
            2'd1:    w_load = {9'b0, w_cs};
            2'd2:    w_load = {26'b0, r_nc} + {9'b0, w_rs};
            default: w_load = {9'b0, w_rs};
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_sf   <= tln_pkg::SF_RESET;
            r_nc   <= tln_pkg::NC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tln_pkg::CFG_MODE:     r_mode <= i_cfg_data[0];
                tln_pkg::CFG_SCALE:    r_sf   <= i_cfg_data[tln_pkg::SF_W-1:0];
                tln_pkg::CFG_NUM_COLS: r_nc   <= i_cfg_data[tln_pkg::NC_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            o_out_valid <= 1'b0;
        end else begin
            // result register: load a finished word, or drop one that was taken
            if (r_state == S_OUT && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_opcode)
                            tln_pkg::OP_ACC: r_state <= S_RD;
                            tln_pkg::OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= S_CLR;
                            end
                            tln_pkg::OP_XFORM: begin
                                if (r_mode) begin
                                    r_state <= S_RD;
                                end else begin
                                    r_res   <= {i_entry_value, 16'b0};
                                    r_err   <= tln_pkg::ERR_OK;
                                    r_state <= S_OUT;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RD: begin
                    r_state <= (r_op == tln_pkg::OP_ACC) ? S_ACC : S_CHK;
                end
                S_ACC: r_state <= S_IDLE;
                S_CHK: begin
                    if (w_cs == '0) begin
                        r_res   <= '0;
                        r_err   <= tln_pkg::ERR_COL;
                        r_state <= S_OUT;
                    end else if (w_rs == '0) begin
                        r_res   <= '0;
                        r_err   <= tln_pkg::ERR_ROW;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MA;
                    end
                end
                S_MA: r_state <= S_MAW;
                S_MAW: begin
                    r_a     <= w_prod[39:0];
                    r_lsel  <= 2'd0;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_n     <= w_load;
                    r_sh    <= '0;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_n[tln_pkg::NORM_W-1]) begin
                        r_m     <= r_n[tln_pkg::NORM_W-1 -: 32];
                        r_frac  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SQ0;
                    end else if (r_n[tln_pkg::NORM_W-1 -: 8] == '0) begin
                        r_n  <= r_n << 8;
                        r_sh <= r_sh + 6'd8;
                    end else begin
                        r_n  <= r_n << 1;
                        r_sh <= r_sh + 6'd1;
                    end
                end
                S_SQ0: r_state <= S_SQ;
                S_SQ: begin
                    r_frac <= {r_frac[tln_pkg::FRAC_W-2:0], w_prod[63]};
                    r_m    <= w_mnext;
                    r_cnt  <= r_cnt + 5'd1;
                    if (r_cnt == 5'(tln_pkg::FRAC_W - 1)) begin
                        r_state <= S_LEND;
                    end
                end
                S_LEND: begin
                    case (r_lsel)
                        2'd0: r_hi <= w_log;
                        2'd1: r_t1 <= w_diff[tln_pkg::LOG_W-1:6];
                        2'd2: r_hi <= w_log;
                        default: r_t2 <= w_diff[tln_pkg::LOG_W-1:6];
                    endcase
                    r_lsel  <= r_lsel + 2'd1;
                    r_state <= (r_lsel == 2'd3) ? S_MT : S_LOAD;
                end
                S_MT: r_state <= S_MTW;
                S_MTW: begin
                    r_x     <= w_prod;
                    r_pass  <= 1'b0;
                    r_state <= S_Q1;
                end
                S_Q1: r_state <= S_Q2;
                S_Q2: begin
                    r_acc   <= w_prod;
                    r_state <= S_Q3;
                end
                S_Q3: begin
                    r_x <= r_acc + {32'b0, w_prod[63:32]};
                    if (r_pass) begin
                        r_state <= S_RND;
                    end else begin
                        r_pass  <= 1'b1;
                        r_state <= S_Q1;
                    end
                end
                S_RND: begin
                    r_res   <= w_rnd[63:32];
                    r_err   <= tln_pkg::ERR_OK;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // word capture and result register payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op  <= i_opcode;
            r_row <= i_row_index;
            r_col <= i_col_index;
            r_val <= i_entry_value;
        end
        if (r_state == S_OUT && w_out_free) begin
            o_row_out    <= r_row;
            o_col_out    <= r_col;
            o_norm_value <= r_res;
            o_error_code <= r_err;
        end
    end

    // a flagged result never carries a value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error_code != tln_pkg::ERR_OK) |-> (o_norm_value == '0))
        else $error("error result with nonzero value");

    // squaring keeps the mantissa normalised
    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> r_m[31])
        else $error("mantissa lost its leading one");

    // product before rounding stays inside 60 bits
    a_prod_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND) |-> (r_x[63:60] == 4'b0))
        else $error("scaled product out of range");

    // clearing pass only ends after the last entry
    a_clr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(r_state) == S_CLR && r_state == S_IDLE) |-> ($past(r_clr_addr) == '1))
        else $error("clearing pass ended early");

    // a result is loaded only when the output register is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready && r_state == S_OUT) |=> (r_state == S_OUT))
        else $error("result overwrote a waiting word");

endmodule

// ===== tb/tfidf_log_normalizer_top_tb.sv =====
module tfidf_log_normalizer_top_tb;

    // one input word and one result word
    typedef struct packed {
        logic [1:0]                op;
        logic [tln_pkg::IDX_W-1:0] row;
        logic [tln_pkg::IDX_W-1:0] col;
        logic [tln_pkg::VAL_W-1:0] val;
    } t_entry_word;

    typedef struct packed {
        logic [tln_pkg::IDX_W-1:0] row;
        logic [tln_pkg::IDX_W-1:0] col;
        logic [31:0]               norm;
        logic [1:0]                err;
    } t_norm_word;

    localparam int unsigned STALL_LIMIT = 60000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    logic [tln_pkg::CFG_IDX_W-1:0] i_cfg_idx = tln_pkg::CFG_MODE;
    logic [tln_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    logic [1:0]                    i_opcode = tln_pkg::OP_ACC;
    logic [tln_pkg::IDX_W-1:0]     i_row_index = '0;
    logic [tln_pkg::IDX_W-1:0]     i_col_index = '0;
    logic [tln_pkg::VAL_W-1:0]     i_entry_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [tln_pkg::IDX_W-1:0]     o_row_out;
    logic [tln_pkg::IDX_W-1:0]     o_col_out;
    logic [31:0]                   o_norm_value;
    logic [1:0]                    o_error_code;

    tfidf_log_normalizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_entry_value (i_entry_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_out     (o_row_out),
        .o_col_out     (o_col_out),
        .o_norm_value  (o_norm_value),
        .o_error_code  (o_error_code)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // mirror of the block: sum stores and registers
    logic [tln_pkg::SUM_W-1:0] row_sum_mem [tln_pkg::MEM_DEPTH];
    logic [tln_pkg::SUM_W-1:0] col_sum_mem [tln_pkg::MEM_DEPTH];
    logic                      mdl_mode;
    logic [tln_pkg::SF_W-1:0]  mdl_scale;
    logic [tln_pkg::NC_W-1:0]  mdl_num_cols;

    t_entry_word entry_q [$];
    t_norm_word  norm_q [$];
    t_entry_word cur_word;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned mismatches = 0;
    int unsigned n_acc = 0, n_xform = 0, n_clear = 0, n_ignored = 0;
    int unsigned n_checked = 0, n_err_words = 0;
    int unsigned clears_left = 0;
    int unsigned stall_cnt = 0;

    // log2(n) in Q.30: msb position plus 30 fraction bits by repeated squaring
    function automatic logic [63:0] log2_q30(logic [63:0] n);
        int          p;
        logic [31:0] m;
        logic [63:0] sq;
        logic [63:0] frac;
        p = 0;
        frac = '0;
        if (n == 0) return '0;
        for (int i = 0; i < 64; i++) if (n[i]) p = i;
        if (p >= 31) m = 32'(n >> (p - 31));
        else m = 32'(n << (31 - p));
        for (int i = 0; i < 30; i++) begin
            sq = {32'b0, m} * {32'b0, m};
            frac = frac << 1;
            if (sq[63]) begin
                frac[0] = 1'b1;
                m = sq[63:32];
            end else begin
                m = sq[62:31];
            end
        end
        return (64'(p) << 30) | frac;
    endfunction

    // floor(a * c / 2^32)
    function automatic logic [63:0] scale_q32(logic [63:0] a, logic [31:0] c);
        logic [63:0] lo_part;
        lo_part = {32'b0, a[31:0]} * {32'b0, c};
        return {32'b0, a[63:32]} * {32'b0, c} + (lo_part >> 32);
    endfunction

    // ln(1 + a/b) / ln2 in Q.24, clamped at zero
    function automatic logic [63:0] log_ratio_q24(logic [63:0] a, logic [63:0] b);
        logic [63:0] hi;
        logic [63:0] lo;
        hi = log2_q30(a + b);
        lo = log2_q30(b);
        return (hi > lo) ? (hi - lo) >> 6 : 64'd0;
    endfunction

    function automatic logic [tln_pkg::SUM_W-1:0] sat_add(logic [tln_pkg::SUM_W-1:0] s,
                                                         logic [tln_pkg::VAL_W-1:0] v);
        logic [tln_pkg::SUM_W:0] t;
        t = {1'b0, s} + {{(tln_pkg::SUM_W + 1 - tln_pkg::VAL_W){1'b0}}, v};
        return t[tln_pkg::SUM_W] ? '1 : t[tln_pkg::SUM_W-1:0];
    endfunction

    // apply one accepted word to the mirror, queue the result it gives
    task automatic tfidf_predict(t_entry_word w);
        t_norm_word  r;
        logic [63:0] tf, idf, prod;
        logic [31:0] cs, rs;
        r.row = w.row;
        r.col = w.col;
        r.err = tln_pkg::ERR_OK;
        r.norm = '0;
        case (w.op)
            tln_pkg::OP_ACC: begin
                row_sum_mem[w.row] = sat_add(row_sum_mem[w.row], w.val);
                col_sum_mem[w.col] = sat_add(col_sum_mem[w.col], w.val);
                n_acc++;
            end
            tln_pkg::OP_CLEAR: begin
                for (int i = 0; i < tln_pkg::MEM_DEPTH; i++) begin
                    row_sum_mem[i] = '0;
                    col_sum_mem[i] = '0;
                end
                n_clear++;
            end
            tln_pkg::OP_XFORM: begin
                n_xform++;
                cs = col_sum_mem[w.col];
                rs = row_sum_mem[w.row];
                if (!mdl_mode) begin
                    r.norm = {w.val, 16'b0};
                end else if (cs == 0) begin
                    r.err = tln_pkg::ERR_COL;
                end else if (rs == 0) begin
                    r.err = tln_pkg::ERR_ROW;
                end else begin
                    tf = log_ratio_q24(64'(w.val) * 64'(mdl_scale), 64'(cs));
                    idf = log_ratio_q24(64'(mdl_num_cols), 64'(rs));
                    prod = scale_q32(scale_q32(tf * idf, tln_pkg::LN2_Q32), tln_pkg::LN2_Q32);
                    prod = (prod + (64'd1 << 31)) >> 32;
                    r.norm = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
                end
                if (r.err != tln_pkg::ERR_OK) n_err_words++;
                norm_q.push_back(r);
            end
            default: n_ignored++;
        endcase
    endtask

    // driver: a new word goes out only when the previous one has been taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) tfidf_predict(cur_word);
            if (!i_in_valid || o_in_ready) begin
                if (entry_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = entry_q.pop_front();
                    i_opcode <= cur_word.op;
                    i_row_index <= cur_word.row;
                    i_col_index <= cur_word.col;
                    i_entry_value <= cur_word.val;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: field by field against the oldest expected result
    always @(posedge i_clk) begin
        t_norm_word e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (norm_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word row %0d col %0d norm %h err %0d",
                                 o_row_out, o_col_out, o_norm_value, o_error_code);
                end else begin
                    e = norm_q.pop_front();
                    n_checked++;
                    if (o_row_out !== e.row || o_col_out !== e.col ||
                        o_norm_value !== e.norm || o_error_code !== e.err) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d %0d %h %0d, got %0d %0d %h %0d",
                                     e.row, e.col, e.norm, e.err,
                                     o_row_out, o_col_out, o_norm_value, o_error_code);
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: the clearing pass is the longest legal silence
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cnt);
            $display("tfidf_log_normalizer_top test failed");
            $finish;
        end
    end

    function automatic t_entry_word mk(logic [1:0] op, int row, int col, int val);
        t_entry_word w;
        w.op = op;
        w.row = tln_pkg::IDX_W'(row);
        w.col = tln_pkg::IDX_W'(col);
        w.val = tln_pkg::VAL_W'(val);
        return w;
    endfunction

    // mostly accumulate then transform over a small pool so the sums are live
    function automatic t_entry_word rand_word();
        t_entry_word w;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 50) w.op = tln_pkg::OP_ACC;
        else if (sel < 94) w.op = tln_pkg::OP_XFORM;
        else if (sel < 97 || clears_left == 0) w.op = tln_pkg::OP_IGNORE;
        else begin
            w.op = tln_pkg::OP_CLEAR;
            clears_left--;
        end
        w.row = ($urandom_range(99) < 80) ? tln_pkg::IDX_W'($urandom_range(11))
                                          : tln_pkg::IDX_W'($urandom);
        w.col = ($urandom_range(99) < 80) ? tln_pkg::IDX_W'($urandom_range(11))
                                          : tln_pkg::IDX_W'($urandom);
        if ($urandom_range(99) < 80) w.row[tln_pkg::IDX_W-1] = 1'($urandom_range(1));
        sel = $urandom_range(9);
        if (sel == 0) w.val = '0;
        else if (sel == 1) w.val = '1;
        else if (sel < 5) w.val = tln_pkg::VAL_W'($urandom_range(20));
        else w.val = tln_pkg::VAL_W'($urandom);
        return w;
    endfunction

    task automatic cfg_write(logic [tln_pkg::CFG_IDX_W-1:0] idx,
                             logic [tln_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tln_pkg::CFG_MODE:     mdl_mode = data[0];
            tln_pkg::CFG_SCALE:    mdl_scale = data[tln_pkg::SF_W-1:0];
            tln_pkg::CFG_NUM_COLS: mdl_num_cols = data[tln_pkg::NC_W-1:0];
            default: ;
        endcase
    endtask

    // drain everything, then let a trailing accumulate or clearing pass finish
    task automatic drain();
        while (entry_q.size() > 0 || i_in_valid || norm_q.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_random(int unsigned n, int unsigned s_idle, int unsigned r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        clears_left = 1;
        for (int i = 0; i < n; i++) entry_q.push_back(rand_word());
        drain();
    endtask

    initial begin
        for (int i = 0; i < tln_pkg::MEM_DEPTH; i++) begin
            row_sum_mem[i] = '0;
            col_sum_mem[i] = '0;
        end
        mdl_mode = 1'b1;
        mdl_scale = tln_pkg::SF_RESET;
        mdl_num_cols = tln_pkg::NC_RESET;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty sums, row-only miss, extremes, ignored opcode, clear
        send_idle_pct = 0;
        recv_idle_pct = 0;
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 0, 0, 5));
        entry_q.push_back(mk(tln_pkg::OP_ACC, 1, 1, 5));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 1, 1, 5));
        entry_q.push_back(mk(tln_pkg::OP_ACC, 2, 3, 7));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 4, 3, 9));
        entry_q.push_back(mk(tln_pkg::OP_ACC, 16383, 16383, 65535));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 16383, 16383, 65535));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 16383, 16383, 0));
        entry_q.push_back(mk(tln_pkg::OP_ACC, 16383, 0, 1));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 16383, 0, 65535));
        entry_q.push_back(mk(tln_pkg::OP_IGNORE, 16383, 16383, 65535));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 1, 16383, 1));
        entry_q.push_back(mk(tln_pkg::OP_CLEAR, 0, 0, 0));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 1, 1, 5));
        entry_q.push_back(mk(tln_pkg::OP_ACC, 5, 6, 0));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 5, 6, 3));
        drain();

        // pass-through extremes
        cfg_write(tln_pkg::CFG_MODE, 24'd0);
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 0, 0, 65535));
        entry_q.push_back(mk(tln_pkg::OP_XFORM, 16383, 16383, 0));
        entry_q.push_back(mk(tln_pkg::OP_ACC, 9, 9, 1234));
        drain();

        // smallest scales, busy sender, stalling receiver
        cfg_write(tln_pkg::CFG_MODE, 24'd1);
        cfg_write(tln_pkg::CFG_SCALE, 24'd1);
        cfg_write(tln_pkg::CFG_NUM_COLS, 24'd1);
        run_random(330, 9, 87);

        // largest scale factor, 16384 columns, the other way round
        cfg_write(tln_pkg::CFG_SCALE, 24'hFF_FFFF);
        cfg_write(tln_pkg::CFG_NUM_COLS, 24'd16384);
        run_random(330, 87, 9);

        cfg_write(tln_pkg::CFG_MODE, 24'd0);
        run_random(150, 0, 0);

        // random scale factor, column count at the top of its register range
        cfg_write(tln_pkg::CFG_MODE, 24'd1);
        cfg_write(tln_pkg::CFG_SCALE, tln_pkg::CFG_W'($urandom));
        cfg_write(tln_pkg::CFG_NUM_COLS, 24'd32767);
        run_random(300, 0, 0);

        // zero scales: both log terms collapse
        cfg_write(tln_pkg::CFG_SCALE, 24'd0);
        cfg_write(tln_pkg::CFG_NUM_COLS, 24'd0);
        run_random(60, 0, 0);

        cfg_write(tln_pkg::CFG_SCALE, tln_pkg::CFG_W'(tln_pkg::SF_RESET));
        cfg_write(tln_pkg::CFG_NUM_COLS, tln_pkg::CFG_W'(tln_pkg::NC_RESET));
        run_random(360, 9, 87);

        repeat (300) @(posedge i_clk);
        $display("covered %0d accumulate, %0d transform, %0d clear and %0d ignored words",
                 n_acc, n_xform, n_clear, n_ignored);
        $display("checked %0d result words (%0d with a zero sum), %0d mismatches",
                 n_checked, n_err_words, mismatches);
        if (mismatches == 0 && norm_q.size() == 0) begin
            $display("tfidf_log_normalizer_top test passed");
        end else begin
            if (norm_q.size() > 0) $display("%0d expected results never arrived", norm_q.size());
            $display("tfidf_log_normalizer_top test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/tln_pkg.sv
rtl/core/tln_ram.sv
rtl/core/tln_mul.sv
rtl/core/tfidf_log_normalizer_top.sv
tb/tfidf_log_normalizer_top_tb.sv
